// File: rtl/sapc_pkg.sv
package sapc_pkg;

    // Field widths of the request and response items
    localparam int KEY_W  = 31;
    localparam int SLOT_W = 8;
    localparam int REQ_W  = 2;

    // Default geometry of the directory
    localparam int NUM_SETS_DEF = 16;
    localparam int WAYS_DEF     = 16;

    typedef logic [REQ_W-1:0]  req_type_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [SLOT_W-1:0] slot_t;

    // Request codes
    localparam req_type_t REQ_GET   = 2'd0;
    localparam req_type_t REQ_PUT   = 2'd1;
    localparam req_type_t REQ_DEL   = 2'd2;
    localparam req_type_t REQ_FLUSH = 2'd3;

    typedef struct packed {
        req_type_t req_type;
        key_t      page_key;
    } req_t;

    typedef struct packed {
        logic  found;
        slot_t slot;
        logic  evicted;
        key_t  evicted_key;
    } rsp_t;

    // Sequencer controls for the way scanner
    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctl_t;

    // Status of the set index unit
    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// File: rtl/sapc_ram.sv
module sapc_ram #(
    parameter int WIDTH = sapc_pkg::KEY_W,
    parameter int DEPTH = sapc_pkg::NUM_SETS_DEF * sapc_pkg::WAYS_DEF,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, hold data between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sapc_setidx.sv
module sapc_setidx #(
    parameter int NUM_SETS = sapc_pkg::NUM_SETS_DEF,
    localparam int SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  sapc_pkg::key_t      key,
    output sapc_pkg::div_sts_t  sts,
    output logic [SetW-1:0]     set_idx
);

    // Rounded-up reciprocal of the set count, exact for every key value
    localparam int RecipSh = sapc_pkg::KEY_W + $clog2(NUM_SETS);
    localparam int RecipW  = sapc_pkg::KEY_W + 1;
    localparam int ProdW   = sapc_pkg::KEY_W + RecipW;
    localparam longint unsigned RecipL =
        ((64'd1 << RecipSh) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);
    localparam logic [RecipW-1:0] Recip   = RecipW'(RecipL);
    localparam logic [SetW:0]     Modulus = (SetW + 1)'(NUM_SETS);

    sapc_pkg::key_t   key_reg, key_next;
    logic [SetW:0]    quo_reg, quo_next;
    logic [SetW-1:0]  rem_reg, rem_next;
    logic             mul_reg, mul_next;
    logic             sub_reg, sub_next;
    logic             done_reg, done_next;
    logic [ProdW-1:0] prod;
    logic [SetW:0]    low_prod;
    logic [SetW:0]    diff;

    // Quotient by reciprocal multiply, then the low bits of key minus quotient times sets
    always_comb begin
        prod      = ProdW'(key_reg) * ProdW'(Recip);
        low_prod  = quo_reg * Modulus;
        diff      = key_reg[SetW:0] - low_prod;
        key_next  = key_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        mul_next  = 1'b0;
        sub_next  = 1'b0;
        done_next = 1'b0;
        if (start) begin
            key_next = key;
            mul_next = 1'b1;
        end
        if (mul_reg) begin
            quo_next = prod[RecipSh +: SetW + 1];
            sub_next = 1'b1;
        end
        if (sub_reg) begin
            rem_next  = diff[SetW-1:0];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            mul_reg  <= mul_next;
            sub_reg  <= sub_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign sts.busy = mul_reg || sub_reg;
    assign sts.done = done_reg;
    assign set_idx  = rem_reg;

endmodule

// File: rtl/sapc_scan.sv
module sapc_scan #(
    parameter int WAYS = sapc_pkg::WAYS_DEF,
    localparam int WayW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sapc_pkg::scan_ctl_t  ctl,
    input  logic [WayW-1:0]      way,
    input  logic                 ent_valid,
    input  logic [WayW-1:0]      ent_age,
    input  sapc_pkg::key_t       ent_key,
    input  sapc_pkg::key_t       req_key,
    output logic                 hit,
    output logic [WayW-1:0]      hit_way,
    output logic                 free,
    output logic [WayW-1:0]      free_way,
    output logic [WayW-1:0]      best_age,
    output logic [WayW-1:0]      evict_way,
    output sapc_pkg::key_t       evict_key
);

    logic             hit_reg, hit_next;
    logic             free_reg, free_next;
    logic [WayW-1:0]  hit_way_reg, hit_way_next;
    logic [WayW-1:0]  free_way_reg, free_way_next;
    logic [WayW-1:0]  best_reg, best_next;
    logic [WayW-1:0]  evict_way_reg, evict_way_next;
    sapc_pkg::key_t   evict_key_reg, evict_key_next;

    // Track first hit, first free way and the oldest way, one way a cycle
    always_comb begin
        hit_next       = hit_reg;
        free_next      = free_reg;
        hit_way_next   = hit_way_reg;
        free_way_next  = free_way_reg;
        best_next      = best_reg;
        evict_way_next = evict_way_reg;
        evict_key_next = evict_key_reg;
        if (ctl.clear) begin
            hit_next  = 1'b0;
            free_next = 1'b0;
            best_next = '0;
        end else if (ctl.step) begin
            if (!hit_reg && ent_valid && ent_key == req_key) begin
                hit_next     = 1'b1;
                hit_way_next = way;
            end
            if (!free_reg && !ent_valid) begin
                free_next     = 1'b1;
                free_way_next = way;
            end
            // way zero is the fallback victim when no age beats zero
            if (way == '0 || ent_age > best_reg) begin
                best_next      = ent_age;
                evict_way_next = way;
                evict_key_next = ent_key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else begin
            hit_reg  <= hit_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_way_reg   <= hit_way_next;
        free_way_reg  <= free_way_next;
        best_reg      <= best_next;
        evict_way_reg <= evict_way_next;
        evict_key_reg <= evict_key_next;
    end

    assign hit       = hit_reg;
    assign hit_way   = hit_way_reg;
    assign free      = free_reg;
    assign free_way  = free_way_reg;
    assign best_age  = best_reg;
    assign evict_way = evict_way_reg;
    assign evict_key = evict_key_reg;

endmodule

// File: rtl/set_assoc_page_cache_lru.sv
// Channel  Direction  Ports                      Contents
// s_       in         s_valid s_ready s_data     request: req_type, page_key
// m_       out        m_valid m_ready m_data     response: found, slot, evicted, evicted_key
//
// A get, put or delete passes through the load, scan, update and done states before
// m_valid rises; the next request is taken once the sequencer is back in idle.
// The key memory is read and compared one way per cycle, then, on a hit or a put,
// the age row is rewritten. When NUM_SETS is not a power of two the set index is first
// found by a registered reciprocal multiply and subtract. A flush clears every set flag.
// Reset clears the set flags, so every set reads empty with all ages zero.
// s_ready is high only while idle; a stalled response waits in the output register
// and the next request may be accepted meanwhile.
module set_assoc_page_cache_lru #(
    parameter int NUM_SETS = sapc_pkg::NUM_SETS_DEF,
    parameter int WAYS     = sapc_pkg::WAYS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sapc_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output sapc_pkg::rsp_t  m_data
);

    localparam int SetW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WayW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AgeW   = WayW;
    localparam int LaneW  = AgeW + 1;
    localparam int RowW   = WAYS * LaneW;
    localparam int KeyAw  = (NUM_SETS * WAYS > 1) ? $clog2(NUM_SETS * WAYS) : 1;
    localparam bit SetsPow2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_LOAD = 6'b000100,
        ST_SCAN = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    sapc_pkg::req_t        req_reg, req_next;
    logic [SetW-1:0]       set_reg, set_next;
    logic [WayW-1:0]       chk_way_reg, chk_way_next;
    logic [NUM_SETS-1:0]   flag_reg, flag_next;
    logic                  row_flag_reg, row_flag_next;
    sapc_pkg::rsp_t        res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    sapc_pkg::rsp_t        m_data_reg, m_data_next;

    logic                  accept;
    logic [SetW-1:0]       set_mask;
    logic                  div_start;
    sapc_pkg::div_sts_t    div_sts;
    logic [SetW-1:0]       div_set;

    logic [WayW:0]         rd_way;
    logic                  key_re;
    logic [KeyAw-1:0]      key_raddr;
    sapc_pkg::key_t        key_rdata;
    logic                  key_we;
    logic [KeyAw-1:0]      tgt_addr;
    logic                  row_re;
    logic                  row_we;
    logic [RowW-1:0]       row_rdata;
    logic [RowW-1:0]       new_row;

    logic                  row_v [WAYS];
    logic [AgeW-1:0]       row_a [WAYS];
    logic                  new_v [WAYS];
    logic [AgeW-1:0]       new_a [WAYS];

    sapc_pkg::scan_ctl_t   scan_ctl;
    logic                  scan_hit;
    logic [WayW-1:0]       scan_hit_way;
    logic                  scan_free;
    logic [WayW-1:0]       scan_free_way;
    logic [WayW-1:0]       scan_best_age;
    logic [WayW-1:0]       scan_evict_way;
    sapc_pkg::key_t        scan_evict_key;

    logic                  is_get, is_put, is_del;
    logic                  put_new, do_evict;
    logic [WayW-1:0]       tgt_way;
    logic [AgeW-1:0]       pivot;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign set_mask = SetW'(s_data.page_key & sapc_pkg::key_t'(NUM_SETS - 1));

    // Set index unit for set counts that are not a power of two
    assign div_start = accept && !SetsPow2 && (s_data.req_type != sapc_pkg::REQ_FLUSH);

    sapc_setidx #(
        .NUM_SETS (NUM_SETS)
    ) u_setidx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .key     (s_data.page_key),
        .sts     (div_sts),
        .set_idx (div_set)
    );

    // Key store: one read per way during the scan, one write on insertion
    assign rd_way    = (state_reg == ST_LOAD) ? '0 : ({1'b0, chk_way_reg} + 1'b1);
    assign key_re    = (state_reg == ST_LOAD) ||
                       ((state_reg == ST_SCAN) && (rd_way < (WayW + 1)'(WAYS)));
    assign key_raddr = KeyAw'(set_reg) * KeyAw'(WAYS) + KeyAw'(rd_way);
    assign tgt_addr  = KeyAw'(set_reg) * KeyAw'(WAYS) + KeyAw'(tgt_way);

    sapc_ram #(
        .WIDTH (sapc_pkg::KEY_W),
        .DEPTH (NUM_SETS * WAYS)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_we),
        .wr_addr (tgt_addr),
        .wr_data (req_reg.page_key),
        .rd_en   (key_re),
        .rd_addr (key_raddr),
        .rd_data (key_rdata)
    );

    // Recency store: one row per set, a valid bit and an age per way
    assign row_re = (state_reg == ST_LOAD);

    sapc_ram #(
        .WIDTH (RowW),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (row_we),
        .wr_addr (set_reg),
        .wr_data (new_row),
        .rd_en   (row_re),
        .rd_addr (set_reg),
        .rd_data (row_rdata)
    );

    // Unpack the row; a set untouched since flush or reset reads empty
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            row_v[i] = row_flag_reg & row_rdata[i*LaneW + AgeW];
            row_a[i] = row_flag_reg ? row_rdata[i*LaneW +: AgeW] : '0;
        end
    end

    // Way scanner
    assign scan_ctl.clear = (state_reg == ST_LOAD);
    assign scan_ctl.step  = (state_reg == ST_SCAN);

    sapc_scan #(
        .WAYS (WAYS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .way       (chk_way_reg),
        .ent_valid (row_v[chk_way_reg]),
        .ent_age   (row_a[chk_way_reg]),
        .ent_key   (key_rdata),
        .req_key   (req_reg.page_key),
        .hit       (scan_hit),
        .hit_way   (scan_hit_way),
        .free      (scan_free),
        .free_way  (scan_free_way),
        .best_age  (scan_best_age),
        .evict_way (scan_evict_way),
        .evict_key (scan_evict_key)
    );

    // Decide the request and form the new ages of the set
    assign is_get   = (req_reg.req_type == sapc_pkg::REQ_GET);
    assign is_put   = (req_reg.req_type == sapc_pkg::REQ_PUT);
    assign is_del   = (req_reg.req_type == sapc_pkg::REQ_DEL);
    assign put_new  = is_put && !scan_hit;
    assign do_evict = put_new && !scan_free;
    assign tgt_way  = put_new ? (scan_free ? scan_free_way : scan_evict_way) : scan_hit_way;
    assign pivot    = row_a[scan_hit_way];

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            new_v[i] = row_v[i];
            new_a[i] = row_a[i];
            if ((is_get || is_put) && scan_hit) begin
                // promote the hit, age every younger entry
                if (WayW'(i) == scan_hit_way) begin
                    new_a[i] = '0;
                end else if (row_v[i] && row_a[i] < pivot) begin
                    new_a[i] = row_a[i] + 1'b1;
                end
            end else if (put_new) begin
                if (do_evict && WayW'(i) == scan_evict_way) begin
                    new_v[i] = 1'b0;
                end
                if (do_evict && new_v[i] && row_a[i] > scan_best_age) begin
                    new_a[i] = row_a[i] - 1'b1;
                end
                if (new_v[i]) begin
                    new_a[i] = new_a[i] + 1'b1;
                end
                if (WayW'(i) == tgt_way) begin
                    new_v[i] = 1'b1;
                    new_a[i] = '0;
                end
            end else if (is_del && scan_hit) begin
                // drop the entry, close the gap above it
                if (WayW'(i) == scan_hit_way) begin
                    new_v[i] = 1'b0;
                    new_a[i] = '0;
                end else if (row_v[i] && row_a[i] > pivot) begin
                    new_a[i] = row_a[i] - 1'b1;
                end
            end
            new_row[i*LaneW +: LaneW] = {new_v[i], new_a[i]};
        end
    end

    assign row_we = (state_reg == ST_UPD) && (scan_hit || is_put);
    assign key_we = (state_reg == ST_UPD) && put_new;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        set_next      = set_reg;
        chk_way_next  = chk_way_reg;
        flag_next     = flag_reg;
        row_flag_next = row_flag_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next = s_data;
                    set_next = set_mask;
                    if (s_data.req_type == sapc_pkg::REQ_FLUSH) begin
                        flag_next  = '0;
                        res_next   = '0;
                        state_next = ST_DONE;
                    end else if (SetsPow2) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    set_next   = div_set;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                row_flag_next = flag_reg[set_reg];
                chk_way_next  = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                chk_way_next = chk_way_reg + 1'b1;
                if (chk_way_reg == WayW'(WAYS - 1)) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (row_we) begin
                    flag_next[set_reg] = 1'b1;
                end
                res_next.found       = scan_hit;
                res_next.slot        = (scan_hit || is_put) ? sapc_pkg::slot_t'(tgt_addr) : '0;
                res_next.evicted     = do_evict;
                res_next.evicted_key = do_evict ? scan_evict_key : '0;
                state_next           = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            flag_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            flag_reg    <= flag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        set_reg      <= set_next;
        chk_way_reg  <= chk_way_next;
        row_flag_reg <= row_flag_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.req_type == sapc_pkg::REQ_FLUSH |=> flag_reg == '0)
        else $error("flush left a set flag standing");

    a_evict_not_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.evicted && m_data.found))
        else $error("response reports both a hit and an eviction");

    a_key_port_split: assert property (@(posedge aclk) disable iff (!aresetn)
        key_we |-> !key_re && !row_re)
        else $error("key store written while a scan read is in flight");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request taken while the previous one is still at work");

endmodule
